FILE: rtl/cli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cli_pkg
// Shared sizes, request codes, status codes and the response record of the
// circular list block.
// ----------------------------------------------------------------------------
package cli_pkg;

    // List capacity and derived widths
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int KIND_W = 2;
    localparam int POS_W  = 7;
    localparam int LEN_W  = 7;
    localparam int STAT_W = 2;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_INS_FRONT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEL_FRONT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEL_END   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DEL_POS   = 2'd3;

    // Response status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

    // Response record held until the output register is free
    typedef struct packed {
        logic        [STAT_W-1:0] status;
        logic signed [DATA_W-1:0] removed_value;
    } t_rsp;

endpackage

FILE: rtl/cli_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cli_req_if
// Request channel: valid/ready handshake carrying kind, value and position.
// ----------------------------------------------------------------------------
interface cli_req_if;
    logic                                 valid;
    logic                                 ready;
    logic        [cli_pkg::KIND_W-1:0]    kind;
    logic signed [cli_pkg::DATA_W-1:0]    value;
    logic        [cli_pkg::POS_W-1:0]     position;

    modport source (output valid, output kind, output value, output position,
                    input ready);
    modport sink   (input valid, input kind, input value, input position,
                    output ready);
endinterface

FILE: rtl/cli_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cli_rsp_if
// Response channel: valid/ready handshake carrying status, removed value and
// list length.
// ----------------------------------------------------------------------------
interface cli_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic        [cli_pkg::STAT_W-1:0]    status;
    logic signed [cli_pkg::DATA_W-1:0]    removed_value;
    logic        [cli_pkg::LEN_W-1:0]     length;

    modport source (output valid, output status, output removed_value,
                    output length, input ready);
    modport sink   (input valid, input status, input removed_value,
                    input length, output ready);
endinterface

FILE: rtl/circular_list_insert_delete.sv
`timescale 1ns / 1ps
// Sequencing: insert and rejected requests go from acceptance straight to
//   S_RESP; delete front and delete end pass through S_READ, then S_RESP;
//   delete at position also moves the tail up in S_SHIFT, one entry per cycle
//   through the single RAM read port. One request is in work at a time; the
//   next is accepted the cycle after its response enters the output register.
// Reset clears head index, element count and handshake state, not the RAM.
// ----------------------------------------------------------------------------
// circular_list_insert_delete
// Bounded ordered list of signed 32-bit values kept in a ring RAM, with
// insert front, delete front, delete end and delete at position.
// ----------------------------------------------------------------------------
module circular_list_insert_delete (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cli_req_if.sink   i_req,
    cli_rsp_if.source o_rsp
);

    localparam int SUM_W = cli_pkg::CNT_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SHIFT,
        S_RESP
    } t_state;

    t_state                       r_state;
    logic [cli_pkg::ADDR_W-1:0]   r_head;
    logic [cli_pkg::CNT_W-1:0]    r_count;
    logic [cli_pkg::CNT_W-1:0]    r_rd;
    logic [cli_pkg::CNT_W-1:0]    r_wr;
    logic                         r_shift;
    cli_pkg::t_rsp                r_res;

    logic                         r_out_valid;
    logic [cli_pkg::STAT_W-1:0]   r_out_status;
    logic [cli_pkg::DATA_W-1:0]   r_out_removed;
    logic [cli_pkg::LEN_W-1:0]    r_out_length;

    logic                         ram_we;
    logic [cli_pkg::ADDR_W-1:0]   ram_waddr;
    logic [cli_pkg::DATA_W-1:0]   ram_wdata;
    logic                         ram_re;
    logic [cli_pkg::ADDR_W-1:0]   ram_raddr;
    logic [cli_pkg::DATA_W-1:0]   ram_rdata;

    logic                         req_acc;
    logic                         is_full;
    logic                         is_empty;
    logic                         pos_bad;
    logic [cli_pkg::ADDR_W-1:0]   head_dec;
    logic [cli_pkg::CNT_W-1:0]    pos_off;
    logic                         more;

    // Ring slot of a list offset: head + offset, folded once into the ring
    function automatic logic [cli_pkg::ADDR_W-1:0] slot_of(
        input logic [cli_pkg::ADDR_W-1:0] head,
        input logic [cli_pkg::CNT_W-1:0]  off
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(off);
        if (sum >= SUM_W'(cli_pkg::DEPTH)) begin
            sum = sum - SUM_W'(cli_pkg::DEPTH);
        end
        return sum[cli_pkg::ADDR_W-1:0];
    endfunction

    // Request decode
    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign is_full     = (r_count == cli_pkg::CNT_W'(cli_pkg::DEPTH));
    assign is_empty    = (r_count == '0);
    assign pos_bad     = (i_req.position == '0) ||
                         (SUM_W'(i_req.position) > SUM_W'(r_count));
    assign head_dec    = (r_head == '0) ? cli_pkg::ADDR_W'(cli_pkg::DEPTH - 1)
                                        : r_head - 1'b1;
    assign pos_off     = cli_pkg::CNT_W'(i_req.position) - 1'b1;
    assign more        = (r_rd < r_count);

    // RAM port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = head_dec;
        ram_wdata = i_req.value;
        ram_re    = 1'b0;
        ram_raddr = slot_of(r_head, r_rd);
        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    case (i_req.kind)
                        cli_pkg::KIND_INS_FRONT: begin
                            ram_we = !is_full;
                        end
                        cli_pkg::KIND_DEL_FRONT: begin
                            ram_re    = !is_empty;
                            ram_raddr = r_head;
                        end
                        cli_pkg::KIND_DEL_END: begin
                            ram_re    = !is_empty;
                            ram_raddr = slot_of(r_head, r_count - 1'b1);
                        end
                        default: begin
                            ram_re    = !is_empty && !pos_bad;
                            ram_raddr = slot_of(r_head, pos_off);
                        end
                    endcase
                end
            end
            S_READ: begin
                ram_re = r_shift && more;
            end
            S_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = slot_of(r_head, r_wr);
                ram_wdata = ram_rdata;
                ram_re    = more;
            end
            default: begin
            end
        endcase
    end

    cli_ram #(
        .WIDTH (cli_pkg::DATA_W),
        .DEPTH (cli_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer, list bookkeeping and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_shift     <= 1'b0;
        end else begin
            // drop the response once taken, unless a new one replaces it
            if (r_out_valid && o_rsp.ready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        r_res.status        <= cli_pkg::ST_OK;
                        r_res.removed_value <= '0;
                        r_shift             <= 1'b0;
                        r_state             <= S_RESP;
                        case (i_req.kind)
                            cli_pkg::KIND_INS_FRONT: begin
                                if (is_full) begin
                                    r_res.status <= cli_pkg::ST_FULL;
                                end else begin
                                    r_head  <= head_dec;
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            cli_pkg::KIND_DEL_FRONT: begin
                                if (is_empty) begin
                                    r_res.status <= cli_pkg::ST_EMPTY;
                                end else begin
                                    r_head  <= slot_of(r_head, cli_pkg::CNT_W'(1));
                                    r_count <= r_count - 1'b1;
                                    r_state <= S_READ;
                                end
                            end
                            cli_pkg::KIND_DEL_END: begin
                                if (is_empty) begin
                                    r_res.status <= cli_pkg::ST_EMPTY;
                                end else begin
                                    r_count <= r_count - 1'b1;
                                    r_state <= S_READ;
                                end
                            end
                            default: begin
                                if (is_empty) begin
                                    r_res.status <= cli_pkg::ST_EMPTY;
                                end else if (pos_bad) begin
                                    r_res.status <= cli_pkg::ST_INVALID;
                                end else begin
                                    r_rd    <= pos_off + 1'b1;
                                    r_wr    <= pos_off;
                                    r_shift <= 1'b1;
                                    r_state <= S_READ;
                                end
                            end
                        endcase
                    end
                end
                S_READ: begin
                    // capture the deleted entry, then, for delete at position, start moving the tail up
                    r_res.removed_value <= ram_rdata;
                    if (r_shift && more) begin
                        r_rd    <= r_rd + 1'b1;
                        r_state <= S_SHIFT;
                    end else begin
                        if (r_shift) begin
                            r_count <= r_count - 1'b1;
                        end
                        r_state <= S_RESP;
                    end
                end
                S_SHIFT: begin
                    // advance one entry per cycle
                    r_wr <= r_wr + 1'b1;
                    if (more) begin
                        r_rd <= r_rd + 1'b1;
                    end else begin
                        r_count <= r_count - 1'b1;
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    // hold until the output register is free
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid   <= 1'b1;
                        r_out_status  <= r_res.status;
                        r_out_removed <= r_res.removed_value;
                        r_out_length  <= cli_pkg::LEN_W'(r_count);
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.removed_value = r_out_removed;
    assign o_rsp.length        = r_out_length;

`ifndef SYNTH
    // Element count never exceeds the ring capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cli_pkg::CNT_W'(cli_pkg::DEPTH))
        else $error("element count beyond capacity");

    // The tail move never reads and writes the same slot in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("RAM read and write collide on one slot");

    // An accepted request always leaves idle, so no second one slips in
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> (r_state != S_IDLE))
        else $error("request accepted without leaving idle");

    // A failed delete reports zero as the removed value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != cli_pkg::ST_OK)) |-> (r_out_removed == '0))
        else $error("non-zero removed value on a failed request");
`endif

endmodule

FILE: rtl/cli_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cli_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered. Contents are not reset.
// ----------------------------------------------------------------------------
module cli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
